FILE: hw/rtl/ppmrc_pkg.sv
package ppmrc_pkg;

    localparam int CHAN_COUNT = 8;
    localparam int CH_IDX_W   = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
    localparam int CNT_W      = 5;
    localparam int TICK_W     = 16;
    localparam int OVR_W      = 15;

    localparam logic [15:0]      SYNC_THRESHOLD_RST = 16'd8000;
    localparam logic [15:0]      MIN_PULSE_RST      = 16'd900;
    localparam logic [15:0]      MAX_PULSE_RST      = 16'd2100;
    localparam logic [CNT_W-1:0] MIN_CHANNELS_RST   = 5'd4;

    typedef enum logic [1:0] {
        CMD_CAPTURE         = 2'd0,
        CMD_READ            = 2'd1,
        CMD_SET_OVERRIDE    = 2'd2,
        CMD_CLEAR_OVERRIDES = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_SYNC_THRESHOLD = 2'd0,
        CFG_MIN_PULSE      = 2'd1,
        CFG_MAX_PULSE      = 2'd2,
        CFG_MIN_CHANNELS   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [TICK_W-1:0]  capture_count;
        logic [7:0]         channel;
        logic signed [15:0] override_value;
    } item_t;

    typedef struct packed {
        logic [15:0]      pulse_us;
        logic [CNT_W-1:0] valid_channels;
        logic             fresh_data;
        logic             override_accepted;
    } result_t;

    // handshake between the input stage and the result register
    typedef struct packed {
        logic item_valid;
        logic advance;
    } flow_t;

endpackage

FILE: hw/rtl/ppm_rc_channel_decoder_unit.sv
// PPM radio-control channel decoder.
// Input channel (in_valid/in_ready) carries one command per transfer:
// capture edge timestamp, channel read, set override or clear overrides.
// Output channel (out_valid/out_ready) returns exactly one result per
// command: pulse width for reads, published channel count, fresh-data flag
// and override acknowledge.
// A command passes one input register, then the decode logic and channel
// store feeding the result register. Throughput is one command per cycle
// while the receiver does not stall, set by the single state update per
// cycle in the core.
// When the receiver stalls, the result register holds and one further
// command waits in the input register; in_ready then drops.
// Reset clears all channel state, overrides and flags and loads the
// default limits. cfg_we writes a limit register at once; write only
// while no command is in flight.
module ppm_rc_channel_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [15:0]         capture_count,
    input  logic [7:0]          channel,
    input  logic signed [15:0]  override_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         pulse_us,
    output logic [4:0]          valid_channels,
    output logic                fresh_data,
    output logic                override_accepted
);

    ppmrc_pkg::item_t   item_in;
    ppmrc_pkg::item_t   item_s1;
    ppmrc_pkg::result_t result_s1;
    ppmrc_pkg::result_t result_q;
    ppmrc_pkg::flow_t   flow;
    logic               item_valid;
    logic               out_free;

    assign item_in.cmd            = ppmrc_pkg::cmd_t'(cmd);
    assign item_in.capture_count  = capture_count;
    assign item_in.channel        = channel;
    assign item_in.override_value = override_value;

    assign flow.item_valid = item_valid;
    assign flow.advance    = item_valid && out_free;

    ppmrc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .advance    (flow.advance),
        .item_valid (item_valid),
        .item_out   (item_s1)
    );

    ppmrc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (flow.advance),
        .item      (item_s1),
        .result    (result_s1)
    );

    ppmrc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .flow       (flow),
        .result_in  (result_s1),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result_q)
    );

    assign pulse_us          = result_q.pulse_us;
    assign valid_channels    = result_q.valid_channels;
    assign fresh_data        = result_q.fresh_data;
    assign override_accepted = result_q.override_accepted;

endmodule

FILE: hw/rtl/ppmrc_in_stage.sv
module ppmrc_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ppmrc_pkg::item_t     item_in,
    input  logic                 advance,
    output logic                 item_valid,
    output ppmrc_pkg::item_t     item_out
);

    logic             valid_reg;
    logic             valid_next;
    ppmrc_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

FILE: hw/rtl/ppmrc_core.sv
module ppmrc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                advance,
    input  ppmrc_pkg::item_t    item,
    output ppmrc_pkg::result_t  result
);

    localparam int N     = ppmrc_pkg::CHAN_COUNT;
    localparam int IDX_W = ppmrc_pkg::CH_IDX_W;
    localparam int CNT_W = ppmrc_pkg::CNT_W;

    logic [15:0]      sync_thr_reg;
    logic [15:0]      min_pulse_reg;
    logic [15:0]      max_pulse_reg;
    logic [CNT_W-1:0] min_ch_reg;

    logic [15:0]                    prev_cap_reg, prev_cap_next;
    logic [CNT_W-1:0]               ch_cnt_reg, ch_cnt_next;
    logic [CNT_W-1:0]               pub_cnt_reg, pub_cnt_next;
    logic                           fresh_reg, fresh_next;
    logic [ppmrc_pkg::TICK_W-1:0]   raw_reg [N];
    logic [ppmrc_pkg::TICK_W-1:0]   raw_next [N];
    logic [ppmrc_pkg::OVR_W-1:0]    ovr_reg [N];
    logic [ppmrc_pkg::OVR_W-1:0]    ovr_next [N];

    logic [15:0]      gap;
    logic             ch_ok;
    logic [IDX_W-1:0] ch_idx;
    logic [IDX_W-1:0] cnt_idx;
    logic [15:0]      half_width;
    logic [15:0]      clamped;
    logic [15:0]      pulse;
    logic             accepted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_thr_reg  <= ppmrc_pkg::SYNC_THRESHOLD_RST;
            min_pulse_reg <= ppmrc_pkg::MIN_PULSE_RST;
            max_pulse_reg <= ppmrc_pkg::MAX_PULSE_RST;
            min_ch_reg    <= ppmrc_pkg::MIN_CHANNELS_RST;
        end
        else if (cfg_we)
        begin
            unique case (ppmrc_pkg::cfg_idx_t'(cfg_index))
                ppmrc_pkg::CFG_SYNC_THRESHOLD: sync_thr_reg  <= cfg_data;
                ppmrc_pkg::CFG_MIN_PULSE:      min_pulse_reg <= cfg_data;
                ppmrc_pkg::CFG_MAX_PULSE:      max_pulse_reg <= cfg_data;
                ppmrc_pkg::CFG_MIN_CHANNELS:   min_ch_reg    <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign gap     = item.capture_count - prev_cap_reg;
    assign ch_ok   = item.channel < 8'(N);
    assign ch_idx  = item.channel[IDX_W-1:0];
    assign cnt_idx = ch_cnt_reg[IDX_W-1:0];

    // stored ticks are half microseconds
    assign half_width = {1'b0, raw_reg[ch_idx][15:1]};

    // crossed limits: the upper limit is tested first
    always_comb
    begin
        priority if (half_width > max_pulse_reg)
            clamped = max_pulse_reg;
        else if (half_width < min_pulse_reg)
            clamped = min_pulse_reg;
        else
            clamped = half_width;
    end

    always_comb
    begin
        prev_cap_next = prev_cap_reg;
        ch_cnt_next   = ch_cnt_reg;
        pub_cnt_next  = pub_cnt_reg;
        fresh_next    = fresh_reg;
        raw_next      = raw_reg;
        ovr_next      = ovr_reg;
        pulse         = 16'd0;
        accepted      = 1'b0;

        unique case (item.cmd)
            ppmrc_pkg::CMD_CAPTURE:
            begin
                prev_cap_next = item.capture_count;
                if (gap > sync_thr_reg)
                begin
                    if (ch_cnt_reg >= min_ch_reg)
                    begin
                        pub_cnt_next = ch_cnt_reg;
                        fresh_next   = 1'b1;
                    end
                    ch_cnt_next = '0;
                end
                else if (ch_cnt_reg < CNT_W'(N))
                begin
                    raw_next[cnt_idx] = gap;
                    ch_cnt_next       = ch_cnt_reg + CNT_W'(1);
                    if (ch_cnt_reg == CNT_W'(N - 1))
                    begin
                        pub_cnt_next = CNT_W'(N);
                        fresh_next   = 1'b1;
                    end
                end
            end
            ppmrc_pkg::CMD_READ:
            begin
                if (ch_ok)
                begin
                    fresh_next = 1'b0;
                    if (ovr_reg[ch_idx] != '0)
                        pulse = {1'b0, ovr_reg[ch_idx]};
                    else
                        pulse = clamped;
                end
            end
            ppmrc_pkg::CMD_SET_OVERRIDE:
            begin
                // negative value leaves the store alone
                if (!item.override_value[15] && ch_ok)
                begin
                    ovr_next[ch_idx] = item.override_value[14:0];
                    if (item.override_value[14:0] != '0)
                    begin
                        fresh_next = 1'b1;
                        accepted   = 1'b1;
                    end
                end
            end
            ppmrc_pkg::CMD_CLEAR_OVERRIDES:
            begin
                for (int i = 0; i < N; i++)
                    ovr_next[i] = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cap_reg <= '0;
            ch_cnt_reg   <= '0;
            pub_cnt_reg  <= '0;
            fresh_reg    <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                raw_reg[i] <= '0;
                ovr_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            prev_cap_reg <= prev_cap_next;
            ch_cnt_reg   <= ch_cnt_next;
            pub_cnt_reg  <= pub_cnt_next;
            fresh_reg    <= fresh_next;
            raw_reg      <= raw_next;
            ovr_reg      <= ovr_next;
        end
    end

    assign result.pulse_us          = pulse;
    assign result.valid_channels    = pub_cnt_next;
    assign result.fresh_data        = fresh_next;
    assign result.override_accepted = accepted;

endmodule

FILE: hw/rtl/ppmrc_out_stage.sv
module ppmrc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  ppmrc_pkg::flow_t    flow,
    input  ppmrc_pkg::result_t  result_in,
    output logic                out_free,
    output logic                out_valid,
    input  logic                out_ready,
    output ppmrc_pkg::result_t  result_out
);

    logic               valid_reg;
    logic               valid_next;
    ppmrc_pkg::result_t result_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = flow.advance ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.advance && flow.item_valid)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

FILE: hw/rtl/ppmrc_checker.sv
module ppmrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] pulse_us,
    input logic [4:0]  valid_channels,
    input logic        fresh_data,
    input logic        override_accepted
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pulse_us)
            && $stable(valid_channels) && $stable(fresh_data))
        else $error("result changed while stalled");

    a_ack_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && override_accepted |-> fresh_data)
        else $error("accepted override without fresh-data flag");

    a_ack_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && override_accepted |-> pulse_us == 16'd0)
        else $error("override acknowledge carries a pulse width");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> valid_channels <= 5'(ppmrc_pkg::CHAN_COUNT))
        else $error("published channel count beyond store size");

endmodule

bind ppm_rc_channel_decoder_unit ppmrc_checker u_ppmrc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .pulse_us          (pulse_us),
    .valid_channels    (valid_channels),
    .fresh_data        (fresh_data),
    .override_accepted (override_accepted)
);
